FILE: rtl/lcht_pkg.sv
// shared types and constants for the lba to chs translator
package lcht_pkg;

  // geometry widths
  localparam int HEAD_COUNT_W = 5;
  localparam int SPT_W        = 8;
  localparam int SPC_W        = HEAD_COUNT_W + SPT_W;
  localparam int HEAD_Q_W     = HEAD_COUNT_W;
  localparam int CYL_W        = 16;
  localparam int HEAD_W       = 4;
  localparam int DHB_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_COUNT        = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS_PER_TRACK = 1'b1;

  // geometry after reset
  localparam logic [HEAD_COUNT_W-1:0] HEAD_COUNT_RESET = 5'd16;
  localparam logic [SPT_W-1:0]        SPT_RESET        = 8'd63;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_GEOMETRY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CYL_OVERFLOW  = 2'd2;

  // task file drive/head byte
  localparam logic [DHB_W-1:0] DH_FIXED_BITS = 8'hA0;
  localparam logic [DHB_W-1:0] DH_HEAD_MASK  = 8'h0F;
  localparam logic [DHB_W-1:0] DH_HIGH_MASK  = 8'hF0;

  // data riding along the cylinder division
  typedef struct packed {
    logic             drive;
    logic             zero_geom;
    logic [SPT_W-1:0] spt;
  } div1_side_t;

  // data riding along the head division
  typedef struct packed {
    logic             drive;
    logic             zero_geom;
    logic             cyl_ovf;
    logic [CYL_W-1:0] cyl;
  } div2_side_t;

endpackage

FILE: rtl/lba_to_chs_translator.sv
// top level of the lba to chs translator
// Translates a logical block address into cylinder, head, sector and the task
// file drive/head byte using the programmed geometry. A request is taken every
// cycle while in_stall is low; each one passes through a row of division cells,
// one quotient bit per cell: ADDRESS_BITS cells divide by sectors per cylinder,
// then five cells divide the remainder by sectors per track. Each request passes
// the entry stage, both cell rows and the result register. A stall on the
// result side only freezes occupied cells, so empty slots keep filling.
// Configuration writes are always ready and take effect for requests that
// arrive on the following cycle. Zero geometry gives status 1 with zeroed
// address fields; a cylinder above 65535 gives status 2 with its low 16 bits.
module lba_to_chs_translator #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcht_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lcht_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ADDRESS_BITS-1:0]             logical_block,
  input  logic                                drive_select,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lcht_pkg::CYL_W-1:0]          cylinder,
  output logic [lcht_pkg::HEAD_W-1:0]         head,
  output logic [lcht_pkg::SPT_W-1:0]          sector,
  output logic [lcht_pkg::DHB_W-1:0]          drive_head_byte,
  output logic [lcht_pkg::STATUS_W-1:0]       status
);
  import lcht_pkg::*;

  localparam int S1_BITS = $bits(div1_side_t);
  localparam int S2_BITS = $bits(div2_side_t);

  logic [HEAD_COUNT_W-1:0] head_count;
  logic [SPT_W-1:0]        sectors_per_track;

  // first row: cylinder division
  logic                    c1_valid [0:ADDRESS_BITS];
  logic                    c1_hold  [0:ADDRESS_BITS];
  logic [SPC_W-1:0]        c1_rem   [0:ADDRESS_BITS];
  logic [ADDRESS_BITS-1:0] c1_num   [0:ADDRESS_BITS];
  logic [SPC_W-1:0]        c1_den   [0:ADDRESS_BITS];
  logic [S1_BITS-1:0]      c1_side  [0:ADDRESS_BITS];
  div1_side_t              entry_side;
  div1_side_t              c1_last;

  // second row: head division
  logic                    c2_valid [0:HEAD_Q_W];
  logic                    c2_hold  [0:HEAD_Q_W];
  logic [SPT_W-1:0]        c2_rem   [0:HEAD_Q_W];
  logic [HEAD_Q_W-1:0]     c2_num   [0:HEAD_Q_W];
  logic [SPT_W-1:0]        c2_den   [0:HEAD_Q_W];
  logic [S2_BITS-1:0]      c2_side  [0:HEAD_Q_W];
  div2_side_t              c2_first;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_count        <= HEAD_COUNT_RESET;
      sectors_per_track <= SPT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEAD_COUNT:        head_count        <= cfg_data[HEAD_COUNT_W-1:0];
        CFG_SECTORS_PER_TRACK: sectors_per_track <= cfg_data[SPT_W-1:0];
        default: ;
      endcase
    end
  end

  // entry stage
  lcht_entry_stage #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_entry (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .logical_block    (logical_block),
    .drive_select     (drive_select),
    .head_count       (head_count),
    .sectors_per_track(sectors_per_track),
    .in_stall         (in_stall),
    .valid            (c1_valid[0]),
    .lba              (c1_num[0]),
    .spc              (c1_den[0]),
    .side             (entry_side),
    .down_hold        (c1_hold[0])
  );

  assign c1_rem[0]  = '0;
  assign c1_side[0] = entry_side;

  // cylinder division cells
  for (genvar i = 0; i < ADDRESS_BITS; i++) begin : g_cyl
    lcht_div_cell #(
      .NUM_BITS (ADDRESS_BITS),
      .DEN_BITS (SPC_W),
      .SIDE_BITS(S1_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c1_valid[i]),
      .up_rem   (c1_rem[i]),
      .up_num   (c1_num[i]),
      .up_den   (c1_den[i]),
      .up_side  (c1_side[i]),
      .up_hold  (c1_hold[i]),
      .valid    (c1_valid[i+1]),
      .rem      (c1_rem[i+1]),
      .num      (c1_num[i+1]),
      .den      (c1_den[i+1]),
      .side     (c1_side[i+1]),
      .down_hold(c1_hold[i+1])
    );
  end

  // hand over to the head division; the remainder's top bits stay below spt
  assign c1_last            = div1_side_t'(c1_side[ADDRESS_BITS]);
  assign c1_hold[ADDRESS_BITS] = c2_hold[0];
  assign c2_valid[0]        = c1_valid[ADDRESS_BITS];
  assign c2_rem[0]          = c1_rem[ADDRESS_BITS][SPC_W-1:HEAD_Q_W];
  assign c2_num[0]          = c1_rem[ADDRESS_BITS][HEAD_Q_W-1:0];
  assign c2_den[0]          = c1_last.spt;
  assign c2_first.drive     = c1_last.drive;
  assign c2_first.zero_geom = c1_last.zero_geom;
  assign c2_first.cyl_ovf   = |c1_num[ADDRESS_BITS][ADDRESS_BITS-1:CYL_W];
  assign c2_first.cyl       = c1_num[ADDRESS_BITS][CYL_W-1:0];
  assign c2_side[0]         = c2_first;

  // head division cells
  for (genvar j = 0; j < HEAD_Q_W; j++) begin : g_head
    lcht_div_cell #(
      .NUM_BITS (HEAD_Q_W),
      .DEN_BITS (SPT_W),
      .SIDE_BITS(S2_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c2_valid[j]),
      .up_rem   (c2_rem[j]),
      .up_num   (c2_num[j]),
      .up_den   (c2_den[j]),
      .up_side  (c2_side[j]),
      .up_hold  (c2_hold[j]),
      .valid    (c2_valid[j+1]),
      .rem      (c2_rem[j+1]),
      .num      (c2_num[j+1]),
      .den      (c2_den[j+1]),
      .side     (c2_side[j+1]),
      .down_hold(c2_hold[j+1])
    );
  end

  // result register
  lcht_result_stage u_result (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (c2_valid[HEAD_Q_W]),
    .head_quot      (c2_num[HEAD_Q_W]),
    .sector_rem     (c2_rem[HEAD_Q_W]),
    .up_side        (div2_side_t'(c2_side[HEAD_Q_W])),
    .up_hold        (c2_hold[HEAD_Q_W]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cylinder       (cylinder),
    .head           (head),
    .sector         (sector),
    .drive_head_byte(drive_head_byte),
    .status         (status)
  );

  // input can only be stalled by a full row behind a stalled result
  a_stall_needs_full_pipe: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && c1_valid[0]))
    else $error("input stalled without a stalled result");

  // a good geometry always gives a one-based sector
  a_sector_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ZERO_GEOMETRY) |-> (sector != '0))
    else $error("zero sector on a valid geometry");

  // drive/head byte carries the head number
  a_dh_head: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_head_byte[HEAD_W-1:0] == head))
    else $error("drive/head byte disagrees with head");

  // status code is one of the defined ones
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_ZERO_GEOMETRY ||
                   status == ST_CYL_OVERFLOW))
    else $error("undefined status code");

endmodule

FILE: rtl/lcht_div_cell.sv
// one restoring division cell: produces one quotient bit per request
module lcht_div_cell #(
  parameter int NUM_BITS  = 32,
  parameter int DEN_BITS  = 13,
  parameter int SIDE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  input  logic [DEN_BITS-1:0]  up_rem,
  input  logic [NUM_BITS-1:0]  up_num,
  input  logic [DEN_BITS-1:0]  up_den,
  input  logic [SIDE_BITS-1:0] up_side,
  output logic                 up_hold,
  output logic                 valid,
  output logic [DEN_BITS-1:0]  rem,
  output logic [NUM_BITS-1:0]  num,
  output logic [DEN_BITS-1:0]  den,
  output logic [SIDE_BITS-1:0] side,
  input  logic                 down_hold
);

  logic                load;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS+1:0] diff;
  logic                borrow;
  logic [DEN_BITS-1:0] rem_next;
  logic [NUM_BITS-1:0] num_next;

  // cell keeps its request only while the neighbor downstream holds too
  assign up_hold = valid & down_hold;
  assign load    = ~up_hold;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted  = {up_rem, up_num[NUM_BITS-1]};
  assign diff     = {1'b0, shifted} - {2'b00, up_den};
  assign borrow   = diff[DEN_BITS+1];
  assign rem_next = borrow ? shifted[DEN_BITS-1:0] : diff[DEN_BITS-1:0];
  assign num_next = {up_num[NUM_BITS-2:0], ~borrow};

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      rem  <= rem_next;
      num  <= num_next;
      den  <= up_den;
      side <= up_side;
    end
  end

endmodule

FILE: rtl/lcht_entry_stage.sv
// entry stage: captures a request with its geometry and sectors per cylinder
module lcht_entry_stage #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [ADDRESS_BITS-1:0]             logical_block,
  input  logic                                drive_select,
  input  logic [lcht_pkg::HEAD_COUNT_W-1:0]   head_count,
  input  logic [lcht_pkg::SPT_W-1:0]          sectors_per_track,
  output logic                                in_stall,
  output logic                                valid,
  output logic [ADDRESS_BITS-1:0]             lba,
  output logic [lcht_pkg::SPC_W-1:0]          spc,
  output lcht_pkg::div1_side_t                side,
  input  logic                                down_hold
);
  import lcht_pkg::*;

  logic [SPC_W-1:0] spc_next;
  logic             load;

  assign in_stall = valid & down_hold;
  assign load     = ~in_stall;

  // sectors per cylinder, at most 31 * 255
  assign spc_next = SPC_W'(head_count) * SPC_W'(sectors_per_track);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      lba            <= logical_block;
      spc            <= spc_next;
      side.drive     <= drive_select;
      side.zero_geom <= (head_count == '0) || (sectors_per_track == '0);
      side.spt       <= sectors_per_track;
    end
  end

endmodule

FILE: rtl/lcht_result_stage.sv
// result stage: forms the disk address fields and holds them for the consumer
module lcht_result_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             up_valid,
  input  logic [lcht_pkg::HEAD_Q_W-1:0]    head_quot,
  input  logic [lcht_pkg::SPT_W-1:0]       sector_rem,
  input  lcht_pkg::div2_side_t             up_side,
  output logic                             up_hold,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lcht_pkg::CYL_W-1:0]       cylinder,
  output logic [lcht_pkg::HEAD_W-1:0]      head,
  output logic [lcht_pkg::SPT_W-1:0]       sector,
  output logic [lcht_pkg::DHB_W-1:0]       drive_head_byte,
  output logic [lcht_pkg::STATUS_W-1:0]    status
);
  import lcht_pkg::*;

  logic                load;
  logic [HEAD_W-1:0]   head_next;
  logic [DHB_W-1:0]    dh_base;
  logic [STATUS_W-1:0] status_next;

  assign up_hold = out_valid & out_stall;
  assign load    = ~up_hold;

  // zero geometry forces the address fields to zero
  assign head_next = up_side.zero_geom ? '0 : head_quot[HEAD_W-1:0];
  assign dh_base   = (DH_FIXED_BITS | {3'b000, up_side.drive, 4'b0000}) & DH_HIGH_MASK;

  always_comb begin
    if (up_side.zero_geom) begin
      status_next = ST_ZERO_GEOMETRY;
    end else if (up_side.cyl_ovf) begin
      status_next = ST_CYL_OVERFLOW;
    end else begin
      status_next = ST_OK;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      cylinder        <= up_side.zero_geom ? '0 : up_side.cyl;
      head            <= head_next;
      sector          <= up_side.zero_geom ? '0 : sector_rem + 8'd1;
      drive_head_byte <= dh_base | (DHB_W'(head_next) & DH_HEAD_MASK);
      status          <= status_next;
    end
  end

endmodule

FILE: test/testbench.sv
// testbench for the lba to chs translator: directed and random requests checked against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcht_pkg::*;

  localparam int ADDRESS_BITS = 32;
  localparam int LATENCY      = ADDRESS_BITS + 7;

  // one translated disk address
  typedef struct {
    logic [CYL_W-1:0]    cyl;
    logic [HEAD_W-1:0]   head;
    logic [SPT_W-1:0]    sector;
    logic [DHB_W-1:0]    dhb;
    logic [STATUS_W-1:0] status;
  } chs_addr_t;

  // predicts the disk address of each request and checks results in order
  class chs_scoreboard;
    logic [HEAD_COUNT_W-1:0] heads;
    logic [SPT_W-1:0]        spt;
    chs_addr_t               expected_chs[$];
    int                      mismatches;

    function new();
      heads      = HEAD_COUNT_RESET;
      spt        = SPT_RESET;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_HEAD_COUNT:        heads = data[HEAD_COUNT_W-1:0];
        CFG_SECTORS_PER_TRACK: spt = data[SPT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_chs.size();
    endfunction

    // translate one request with the current geometry
    function void note_request(logic [ADDRESS_BITS-1:0] lba, logic drive);
      logic [63:0] spc;
      logic [63:0] quot;
      logic [63:0] head_full;
      logic [63:0] sec_full;
      chs_addr_t   r;
      r.cyl     = '0;
      r.sector  = '0;
      r.status  = ST_OK;
      head_full = '0;
      if (heads == 0 || spt == 0) begin
        r.status = ST_ZERO_GEOMETRY;
      end else begin
        spc       = 64'(heads) * 64'(spt);
        quot      = 64'(lba) / spc;
        head_full = (64'(lba) % spc) / 64'(spt);
        sec_full  = (64'(lba) % 64'(spt)) + 64'd1;
        r.cyl     = quot[CYL_W-1:0];
        r.sector  = sec_full[SPT_W-1:0];
        if (quot > 64'hFFFF) r.status = ST_CYL_OVERFLOW;
      end
      // head numbers above 15 keep only the low bits
      r.head = head_full[HEAD_W-1:0];
      r.dhb  = ((DH_FIXED_BITS | {3'b000, drive, 4'b0000}) & DH_HIGH_MASK)
             | ({4'b0000, r.head} & DH_HEAD_MASK);
      expected_chs.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_result(logic [CYL_W-1:0] cyl, logic [HEAD_W-1:0] hd, logic [SPT_W-1:0] sec,
                      logic [DHB_W-1:0] dhb, logic [STATUS_W-1:0] st);
      chs_addr_t e;
      if (expected_chs.size() == 0) begin
        report_mismatch("unexpected result, cylinder", cyl, 0);
      end else begin
        e = expected_chs.pop_front();
        if (cyl !== e.cyl) report_mismatch("cylinder", cyl, e.cyl);
        if (hd !== e.head) report_mismatch("head", hd, e.head);
        if (sec !== e.sector) report_mismatch("sector", sec, e.sector);
        if (dhb !== e.dhb) report_mismatch("drive_head_byte", dhb, e.dhb);
        if (st !== e.status) report_mismatch("status", st, e.status);
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = CFG_HEAD_COUNT;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ADDRESS_BITS-1:0] logical_block = '0;
  logic                    drive_select = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CYL_W-1:0]        cylinder;
  logic [HEAD_W-1:0]       head;
  logic [SPT_W-1:0]        sector;
  logic [DHB_W-1:0]        drive_head_byte;
  logic [STATUS_W-1:0]     status;

  // idle rates in percent, and the geometry last programmed
  int                      send_idle = 8;
  int                      recv_idle = 81;
  logic [HEAD_COUNT_W-1:0] cur_heads = HEAD_COUNT_RESET;
  logic [SPT_W-1:0]        cur_spt = SPT_RESET;

  chs_scoreboard sb = new();

  lba_to_chs_translator #(.ADDRESS_BITS(ADDRESS_BITS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .logical_block(logical_block), .drive_select(drive_select),
    .out_valid(out_valid), .out_stall(out_stall),
    .cylinder(cylinder), .head(head), .sector(sector),
    .drive_head_byte(drive_head_byte), .status(status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(logical_block, drive_select);
      if (out_valid && !out_stall)
        sb.check_result(cylinder, head, sector, drive_head_byte, status);
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
    end
  end

  // offer one request, with random idle cycles ahead of it
  task send_request(logic [ADDRESS_BITS-1:0] lba, logic drv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    logical_block <= lba;
    drive_select  <= drv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off new requests until every result is back
  task wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // program both geometry registers while the block is idle
  task write_geometry(logic [HEAD_COUNT_W-1:0] hc, logic [SPT_W-1:0] spt);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HEAD_COUNT;
    cfg_data  <= {3'($urandom_range(7)), hc};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_SECTORS_PER_TRACK;
    cfg_data  <= spt;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_heads = hc;
    cur_spt   = spt;
  endtask

  // random address: fully random, small, or aimed at track, cylinder and overflow boundaries
  function logic [ADDRESS_BITS-1:0] pick_lba();
    logic [63:0] spc;
    logic [63:0] v;
    spc = 64'(cur_heads) * 64'(cur_spt);
    v   = 64'($urandom);
    if (spc != 0) begin
      case ($urandom_range(4))
        0: v = 64'($urandom);
        1: v = 64'($urandom_range(65535)) * spc + 64'($urandom_range(32'(spc - 1)));
        2: v = 64'd65536 * spc + 64'($urandom_range(3)) - 64'd2;
        3: v = 64'($urandom_range(4095));
        default: v = 64'($urandom_range(300)) * 64'(cur_spt)
                   + ($urandom_range(1) ? 64'(cur_spt) - 64'd1 : 64'd0);
      endcase
    end
    return v[ADDRESS_BITS-1:0];
  endfunction

  initial begin
    int hc;
    int spt;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry: track, cylinder and overflow edges
    send_request(0, 1'b0);
    send_request(1, 1'b1);
    send_request(62, 1'b0);
    send_request(63, 1'b1);
    send_request(1007, 1'b0);
    send_request(1008, 1'b1);
    send_request(32'd66060287, 1'b0);
    send_request(32'd66060288, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b1);
    send_request(32'h8000_0000, 1'b0);
    // zero geometry in either register or both
    write_geometry(5'd0, 8'd63);
    send_request(1234, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b0);
    write_geometry(5'd16, 8'd0);
    send_request(32'h5555_AAAA, 1'b1);
    write_geometry(5'd0, 8'd0);
    send_request(32'hAAAA_5555, 1'b0);
    // more than sixteen heads wrap the head number
    write_geometry(5'd31, 8'd255);
    send_request(7904, 1'b1);
    send_request(4080, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);
    // smallest geometry overflows almost at once
    write_geometry(5'd1, 8'd1);
    send_request(65535, 1'b0);
    send_request(65536, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b1);
    write_geometry(5'd16, 8'd255);
    send_request(4079, 1'b0);
    send_request(255, 1'b1);

    // random phases, each with its own geometry; the idle pattern changes every five phases
    for (int p = 0; p < 15; p++) begin
      if (p < 5) begin
        send_idle = 8;
        recv_idle = 81;
      end else if (p < 10) begin
        send_idle = 81;
        recv_idle = 8;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p)
        0: begin hc = 16; spt = 63; end
        1: begin hc = 1; spt = 1; end
        2: begin hc = 31; spt = 255; end
        3: begin hc = 0; spt = $urandom_range(1, 255); end
        4: begin hc = $urandom_range(1, 31); spt = 0; end
        5: begin hc = 16; spt = 255; end
        6: begin hc = 1; spt = 255; end
        7: begin hc = 31; spt = 1; end
        default: begin hc = $urandom_range(1, 16); spt = $urandom_range(1, 255); end
      endcase
      write_geometry(5'(hc), 8'(spt));
      for (int i = 0; i < 50; i++) begin
        send_request(pick_lba(), 1'($urandom_range(1)));
        if (p == 7 && i == 25) wait_drained();
      end
    end
    in_valid <= 1'b0;

    // drain, then leave room for any stray result
    for (int i = 0; i < 20000 && sb.pending() != 0; i++) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results missing", 0, sb.pending());
    if (sb.mismatches == 0) begin
      $display("lba_to_chs_translator test passed");
    end else begin
      $display("lba_to_chs_translator test failed");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #2_400_000;
    $display("lba_to_chs_translator test failed");
    $finish;
  end

endmodule
